### hw/rtl/dtrc_pkg.sv
// Shared types and constants for the deadband thermostat relay controller.
// Used by dtrc_conv and deadband_thermostat_relay_control; no dependencies.
`default_nettype none

package dtrc_pkg;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_HEAT = 2'd2,
      MODE_COOL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_TURN_ON    = 2'd1,
      CMD_TURN_OFF   = 2'd2,
      CMD_SET_TARGET = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_TOLERANCE   = 3'd0,
      CSR_DELAY_TICKS = 3'd1,
      CSR_VALID_MIN   = 3'd2,
      CSR_VALID_MAX   = 3'd3,
      CSR_FAHRENHEIT  = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 48;

   localparam int RSP_FIFO_DEPTH_DEFAULT = 4;

   localparam logic [9:0]         TOLERANCE_RESET   = 10'd16;
   localparam logic [7:0]         DELAY_TICKS_RESET = 8'd5;
   localparam logic signed [15:0] VALID_MIN_RESET   = -16'sd880;
   localparam logic signed [15:0] VALID_MAX_RESET   = 16'sd2000;
   localparam logic signed [15:0] TARGET_RESET      = 16'sd320;

   // Division by five of a magnitude below 2**19 as multiply and shift.
   localparam logic [18:0]        DIV5_RECIP = 19'd419431;
   localparam int                 DIV5_SHIFT = 21;
   localparam logic signed [17:0] F_OFFSET   = 18'sd512;
   localparam logic signed [17:0] SAT_MAX    = 18'sd32767;
   localparam logic signed [17:0] SAT_MIN    = -18'sd32768;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] sample;
      logic signed [15:0] new_target;
   } request_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] temp;
      logic signed [15:0] new_target;
   } stage_type;

   typedef struct packed {
      logic        pad;
      logic [15:0] current_temp;
      logic [15:0] adjust_ticks;
      logic [7:0]  gap_ticks;
      logic        cooler_on;
      logic        heater_on;
      mode_type    next_mode;
      mode_type    mode;
      logic        status;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/dtrc_conv.sv
// Scale conversion stage: turns a raw 1/16 degree Celsius sample into the
// selected scale and registers it with the rest of the command. Uses dtrc_pkg.
`default_nettype none

module dtrc_conv
   import dtrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire request_type in_req,
   input  wire logic        fahrenheit_mode,
   output logic             out_valid,
   output stage_type        out_stage
);

   logic               neg;
   logic [16:0]        mag;
   logic [18:0]        mag9;
   logic [37:0]        prod;
   logic [16:0]        quot;
   logic signed [17:0] signed_quot;
   logic signed [17:0] fahr;
   logic signed [15:0] fahr_sat;
   logic               valid_ff;
   stage_type          stage_ff;
   stage_type          stage_in;

   always_comb begin
      neg         = in_req.sample[15];
      mag         = neg ? 17'(-{in_req.sample[15], in_req.sample})
                        : {1'b0, in_req.sample};
      mag9        = 19'({mag, 3'b000}) + 19'(mag);
      prod        = 38'(mag9) * 38'(DIV5_RECIP);
      quot        = prod[DIV5_SHIFT +: 17];
      signed_quot = neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
      fahr        = signed_quot + F_OFFSET;
      if (fahr > SAT_MAX) begin
         fahr_sat = SAT_MAX[15:0];
      end else if (fahr < SAT_MIN) begin
         fahr_sat = SAT_MIN[15:0];
      end else begin
         fahr_sat = fahr[15:0];
      end
      stage_in.cmd        = in_req.cmd;
      stage_in.new_target = in_req.new_target;
      stage_in.temp       = fahrenheit_mode ? fahr_sat : in_req.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

### hw/rtl/deadband_thermostat_relay_control.sv
// Top level of the deadband heat/cool relay thermostat: input register,
// conversion stage (dtrc_conv), state update and response queue. Uses dtrc_pkg.
`default_nettype none

// Each request transaction yields one response transaction; a new request can
// be accepted on every clock while req_tready is high. The state update is
// combinational and registered as each command leaves dtrc_conv, so commands
// are applied strictly in order. Responses wait in a queue of RSP_FIFO_DEPTH
// entries; req_tready is low only when that queue together with items still
// in the pipeline would be full, which never happens while rsp_tready stays
// high and RSP_FIFO_DEPTH is at least 4. The control registers are written
// through the csr_ port, which is always ready, and should only be written
// while no request is in flight. After reset the block is off, the target is
// 320 (20.0 degrees) and all registers hold their documented reset values.
module deadband_thermostat_relay_control
   import dtrc_pkg::*;
#(
   parameter int RSP_FIFO_DEPTH = RSP_FIFO_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] sample, [31:16] new_target
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] status, [2:1] mode, [4:3] next_mode, [5] heater_on, [6] cooler_on,
   // [14:7] gap_ticks, [30:15] adjust_ticks, [46:31] current_temp, [47] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   logic [9:0]         tolerance_ff;
   logic [7:0]         delay_ticks_ff;
   logic signed [15:0] valid_min_ff;
   logic signed [15:0] valid_max_ff;
   logic               fahrenheit_ff;

   mode_type           mode_ff,        mode_in;
   mode_type           pending_ff,     pending_in;
   logic signed [15:0] target_ff,      target_in;
   logic signed [15:0] last_temp_ff,   last_temp_in;
   logic [7:0]         gap_ff,         gap_in;
   logic [15:0]        adjust_ff,      adjust_in;

   logic               s1_valid_ff;
   request_type        s1_ff;
   request_type        s1_in;
   logic               s2_valid;
   stage_type          s2;

   result_type         result_in;
   result_type         fifo_mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   fifo_cnt_ff;
   logic [CNT_W-1:0]   in_flight;

   logic               req_accept;
   logic               rsp_accept;
   logic               csr_accept;

   logic               status;
   logic               temp_valid;
   logic               target_valid;
   logic signed [17:0] band_lo;
   logic signed [17:0] band_hi;
   logic signed [17:0] temp_wide;
   logic               above;
   logic               below;
   logic [7:0]         gap_inc;
   mode_type           pending_sel;

   assign in_flight  = fifo_cnt_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid);
   assign req_tready = in_flight < CNT_W'(RSP_FIFO_DEPTH);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = fifo_mem_ff[rd_ptr_ff];
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= TOLERANCE_RESET;
         delay_ticks_ff <= DELAY_TICKS_RESET;
         valid_min_ff   <= VALID_MIN_RESET;
         valid_max_ff   <= VALID_MAX_RESET;
         fahrenheit_ff  <= 1'b0;
      end else if (csr_accept) begin
         case (csr_index_type'(csr_index))
            CSR_TOLERANCE:   tolerance_ff   <= csr_wdata[9:0];
            CSR_DELAY_TICKS: delay_ticks_ff <= csr_wdata[7:0];
            CSR_VALID_MIN:   valid_min_ff   <= csr_wdata;
            CSR_VALID_MAX:   valid_max_ff   <= csr_wdata;
            CSR_FAHRENHEIT:  fahrenheit_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_in.cmd        = cmd_type'(req_tuser);
      s1_in.sample     = req_tdata[15:0];
      s1_in.new_target = req_tdata[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   dtrc_conv u_conv (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_req          (s1_ff),
      .fahrenheit_mode (fahrenheit_ff),
      .out_valid       (s2_valid),
      .out_stage       (s2)
   );

   always_comb begin
      mode_in      = mode_ff;
      pending_in   = pending_ff;
      target_in    = target_ff;
      last_temp_in = last_temp_ff;
      gap_in       = gap_ff;
      adjust_in    = adjust_ff;
      status       = 1'b0;

      temp_wide    = 18'(s2.temp);
      band_lo      = 18'(target_ff) - signed'(18'(tolerance_ff));
      band_hi      = 18'(target_ff) + signed'(18'(tolerance_ff));
      above        = temp_wide > band_hi;
      below        = temp_wide < band_lo;
      temp_valid   = (s2.temp > valid_min_ff) && (s2.temp < valid_max_ff);
      target_valid = (s2.new_target > valid_min_ff) && (s2.new_target < valid_max_ff);
      gap_inc      = gap_ff + 8'd1;
      pending_sel  = above ? MODE_COOL : (below ? MODE_HEAT : pending_ff);

      case (s2.cmd)
         CMD_SAMPLE: begin
            last_temp_in = s2.temp;
            if (mode_ff != MODE_OFF && temp_valid) begin
               if (above || below) begin
                  if (mode_ff == MODE_IDLE) begin
                     pending_in = pending_sel;
                     gap_in     = gap_inc;
                     if (gap_inc >= delay_ticks_ff) begin
                        mode_in = pending_sel;
                        gap_in  = 8'd0;
                     end
                  end else begin
                     if (adjust_ff != 16'hFFFF) begin
                        adjust_in = adjust_ff + 16'd1;
                     end
                     pending_in = MODE_IDLE;
                  end
               end else begin
                  mode_in    = MODE_IDLE;
                  pending_in = MODE_IDLE;
                  gap_in     = 8'd0;
                  adjust_in  = 16'd0;
               end
            end
         end
         CMD_TURN_ON:  mode_in = MODE_IDLE;
         CMD_TURN_OFF: mode_in = MODE_OFF;
         CMD_SET_TARGET: begin
            if (target_valid) begin
               target_in = s2.new_target;
            end else begin
               status = 1'b1;
            end
         end
         default: begin
         end
      endcase

      result_in.pad          = 1'b0;
      result_in.current_temp = last_temp_in;
      result_in.adjust_ticks = adjust_in;
      result_in.gap_ticks    = gap_in;
      result_in.cooler_on    = mode_in == MODE_COOL;
      result_in.heater_on    = mode_in == MODE_HEAT;
      result_in.next_mode    = pending_in;
      result_in.mode         = mode_in;
      result_in.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         pending_ff   <= MODE_IDLE;
         target_ff    <= TARGET_RESET;
         last_temp_ff <= 16'sd0;
         gap_ff       <= 8'd0;
         adjust_ff    <= 16'd0;
      end else if (s2_valid) begin
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         target_ff    <= target_in;
         last_temp_ff <= last_temp_in;
         gap_ff       <= gap_in;
         adjust_ff    <= adjust_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid) begin
         fifo_mem_ff[wr_ptr_ff] <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s2_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rsp_accept) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (s2_valid && !rsp_accept) begin
            fifo_cnt_ff <= fifo_cnt_ff + 1'b1;
         end else if (!s2_valid && rsp_accept) begin
            fifo_cnt_ff <= fifo_cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### tb/deadband_thermostat_relay_control_tb.sv
// Self-checking testbench for the deadband thermostat relay controller.
// Runs directed and random command streams through a local prediction of
// the thermostat state. Depends on dtrc_pkg and deadband_thermostat_relay_control.
module deadband_thermostat_relay_control_tb
   import dtrc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int STALL_CYCLES = 300;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   deadband_thermostat_relay_control uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   request_type pending_items[$];
   result_type  due_status[$];

   int send_idle      = 14;
   int recv_idle      = 56;
   int stall_requests = 0;
   int stall_served   = 0;
   int stall_left     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   logic [9:0]         cfg_tol;
   logic [7:0]         cfg_delay;
   logic signed [15:0] cfg_min;
   logic signed [15:0] cfg_max;
   logic               cfg_fahr;

   mode_type           th_mode;
   mode_type           th_pending;
   logic signed [15:0] th_target;
   logic signed [15:0] th_temp;
   logic [7:0]         th_gap;
   logic [15:0]        th_adjust;

   function automatic logic signed [15:0] sat16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic bit reading_valid(int t);
      return (t > int'(cfg_min)) && (t < int'(cfg_max));
   endfunction

   function automatic result_type predict_relay_update(request_type rq);
      result_type r;
      int reading;
      int lo;
      int hi;
      r = '0;
      case (rq.cmd)
         CMD_SAMPLE: begin
            reading = int'(rq.sample);
            if (cfg_fahr) reading = int'(sat16((reading * 9) / 5 + 512));
            th_temp = sat16(reading);
            if (th_mode != MODE_OFF && reading_valid(reading)) begin
               lo = int'(th_target) - int'(cfg_tol);
               hi = int'(th_target) + int'(cfg_tol);
               if (reading < lo || reading > hi) begin
                  if (th_mode == MODE_IDLE) begin
                     th_pending = (reading > hi) ? MODE_COOL : MODE_HEAT;
                     th_gap = th_gap + 8'd1;
                     if (th_gap >= cfg_delay) begin
                        th_mode = th_pending;
                        th_gap = '0;
                     end
                  end else begin
                     if (th_adjust != 16'hFFFF) th_adjust = th_adjust + 16'd1;
                     th_pending = MODE_IDLE;
                  end
               end else begin
                  th_mode = MODE_IDLE;
                  th_pending = MODE_IDLE;
                  th_gap = '0;
                  th_adjust = '0;
               end
            end
         end
         CMD_TURN_ON: th_mode = MODE_IDLE;
         CMD_TURN_OFF: th_mode = MODE_OFF;
         default: begin
            if (reading_valid(int'(rq.new_target))) th_target = rq.new_target;
            else r.status = 1'b1;
         end
      endcase
      r.mode = th_mode;
      r.next_mode = th_pending;
      r.heater_on = (th_mode == MODE_HEAT);
      r.cooler_on = (th_mode == MODE_COOL);
      r.gap_ticks = th_gap;
      r.adjust_ticks = th_adjust;
      r.current_temp = th_temp;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_tol    <= TOLERANCE_RESET;
         cfg_delay  <= DELAY_TICKS_RESET;
         cfg_min    <= VALID_MIN_RESET;
         cfg_max    <= VALID_MAX_RESET;
         cfg_fahr   <= 1'b0;
         th_mode    <= MODE_OFF;
         th_pending <= MODE_IDLE;
         th_target  <= TARGET_RESET;
         th_temp    <= '0;
         th_gap     <= '0;
         th_adjust  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOLERANCE:   cfg_tol <= csr_wdata[9:0];
               CSR_DELAY_TICKS: cfg_delay <= csr_wdata[7:0];
               CSR_VALID_MIN:   cfg_min <= csr_wdata;
               CSR_VALID_MAX:   cfg_max <= csr_wdata;
               CSR_FAHRENHEIT:  cfg_fahr <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            due_status.push_back(predict_relay_update(
               '{cmd: cmd_type'(req_tuser), sample: req_tdata[15:0],
                 new_target: req_tdata[31:16]}));
         end
      end
   end

   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
            nxt = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {nxt.new_target, nxt.sample};
            req_tuser  <= nxt.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_status.size() == 0) begin
               mismatch_count++;
               $error("response transaction with no expected result");
            end else begin
               want = due_status.pop_front();
               check_field("status", want.status, got.status);
               check_field("mode", want.mode, got.mode);
               check_field("next_mode", want.next_mode, got.next_mode);
               check_field("heater_on", want.heater_on, got.heater_on);
               check_field("cooler_on", want.cooler_on, got.cooler_on);
               check_field("gap_ticks", want.gap_ticks, got.gap_ticks);
               check_field("adjust_ticks", want.adjust_ticks, got.adjust_ticks);
               check_field("current_temp", want.current_temp, got.current_temp);
               check_field("pad", 0, got.pad);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_item(cmd_type c, logic [15:0] s, logic [15:0] t);
      pending_items.push_back('{cmd: c, sample: s, new_target: t});
   endtask

   function automatic logic signed [15:0] raw_for(int reading);
      if (cfg_fahr) return sat16(((reading - 512) * 5) / 9);
      return sat16(reading);
   endfunction

   task automatic run_random_phase(int n);
      int made;
      int kind;
      int len;
      int tol;
      int gt;
      int cand;
      cmd_type c;
      logic signed [15:0] t16;
      tol = int'(cfg_tol);
      gt = int'(th_target);
      add_item(CMD_TURN_ON, 16'($urandom), 16'($urandom));
      made = 1;
      while (made < n) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            if ($urandom_range(19) == 0) len = int'(cfg_delay) + 2;
            else len = $urandom_range(1, (cfg_delay > 8) ? 10 : int'(cfg_delay) + 2);
            repeat (len) begin
               cand = tol + 1 + $urandom_range(0, 40);
               add_item(CMD_SAMPLE, raw_for(kind < 35 ? gt + cand : gt - cand),
                        16'($urandom));
            end
            made += len;
         end else if (kind < 80) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
               case ($urandom_range(2))
                  0: cand = tol;
                  1: cand = -tol;
                  default: cand = int'($urandom_range(0, 2 * tol)) - tol;
               endcase
               add_item(CMD_SAMPLE, raw_for(gt + cand), 16'($urandom));
            end
            made += len;
         end else if (kind < 88) begin
            add_item(($urandom_range(3) == 0) ? CMD_TURN_OFF : CMD_TURN_ON,
                     16'($urandom), 16'($urandom));
            made++;
         end else if (kind < 96) begin
            case ($urandom_range(5))
               0: cand = int'(cfg_min);
               1: cand = int'(cfg_max);
               2: cand = int'(cfg_min) + 1;
               3: cand = int'(cfg_max) - 1;
               4: cand = $urandom;
               default: begin
                  if (int'(cfg_max) - int'(cfg_min) > 2)
                     cand = int'(cfg_min) + 1
                            + int'($urandom_range(0, int'(cfg_max) - int'(cfg_min) - 2));
                  else
                     cand = $urandom;
               end
            endcase
            t16 = cand[15:0];
            if (reading_valid(int'(t16))) gt = int'(t16);
            add_item(CMD_SET_TARGET, 16'($urandom), t16);
            made++;
         end else begin
            c = cmd_type'($urandom_range(3));
            t16 = 16'($urandom);
            if (c == CMD_SET_TARGET && reading_valid(int'(t16))) gt = int'(t16);
            add_item(c, 16'($urandom), t16);
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || due_status.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Block starts off: samples are only stored, targets are range checked.
      add_item(CMD_SAMPLE, 16'sd0, 16'sd0);
      add_item(CMD_SAMPLE, 16'sh7FFF, 16'sd0);
      add_item(CMD_SAMPLE, 16'sh8000, 16'sd0);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sh7FFF);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sh8000);
      add_item(CMD_SET_TARGET, 16'sd0, -16'sd880);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sd2000);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sd1999);
      add_item(CMD_SET_TARGET, 16'sd0, -16'sd879);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sd320);
      add_item(CMD_TURN_ON, 16'sd0, 16'sd0);
      add_item(CMD_SAMPLE, 16'sd2000, 16'sd0);
      add_item(CMD_SAMPLE, -16'sd880, 16'sd0);
      repeat (5) add_item(CMD_SAMPLE, 16'sd337, 16'sd0);
      add_item(CMD_SAMPLE, 16'sd336, 16'sd0);
      repeat (6) add_item(CMD_SAMPLE, 16'sd303, 16'sd0);
      add_item(CMD_TURN_OFF, 16'sd0, 16'sd0);
      add_item(CMD_SAMPLE, 16'sd303, 16'sd0);
      add_item(CMD_TURN_ON, 16'sd0, 16'sd0);
      add_item(CMD_SAMPLE, 16'sd304, 16'sd0);
      wait_drained();

      run_random_phase(40);
      stall_requests++;
      run_random_phase(40);
      wait_drained();

      set_reg(CSR_TOLERANCE, 16'd0);
      set_reg(CSR_DELAY_TICKS, 16'd1);
      set_reg(CSR_VALID_MIN, 16'h8000);
      set_reg(CSR_VALID_MAX, 16'h7FFF);
      run_random_phase(80);
      wait_drained();

      send_idle = 56;
      recv_idle = 14;
      set_reg(CSR_TOLERANCE, 16'd1023);
      set_reg(CSR_DELAY_TICKS, 16'd255);
      set_reg(CSR_VALID_MIN, -16'sd20000);
      set_reg(CSR_VALID_MAX, 16'sd20000);
      run_random_phase(80);
      wait_drained();

      set_reg(CSR_FAHRENHEIT, 16'd1);
      set_reg(CSR_TOLERANCE, 16'd32);
      set_reg(CSR_DELAY_TICKS, 16'd3);
      set_reg(CSR_VALID_MIN, 16'sd0);
      set_reg(CSR_VALID_MAX, 16'sd3200);
      add_item(CMD_SAMPLE, 16'sh7FFF, 16'sd0);
      add_item(CMD_SAMPLE, 16'sh8000, 16'sd0);
      run_random_phase(80);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      set_reg(CSR_FAHRENHEIT, 16'd0);
      set_reg(CSR_DELAY_TICKS, 16'd0);
      set_reg(CSR_TOLERANCE, 16'd8);
      set_reg(CSR_VALID_MIN, VALID_MIN_RESET);
      set_reg(CSR_VALID_MAX, VALID_MAX_RESET);
      run_random_phase(60);
      wait_drained();

      set_reg(CSR_VALID_MIN, 16'sd500);
      set_reg(CSR_VALID_MAX, 16'sd500);
      run_random_phase(30);
      wait_drained();

      set_reg(CSR_VALID_MIN, 16'sd2000);
      set_reg(CSR_VALID_MAX, -16'sd880);
      run_random_phase(30);
      wait_drained();

      // A steady heating run keeps counting adjust ticks.
      set_reg(CSR_TOLERANCE, TOLERANCE_RESET);
      set_reg(CSR_DELAY_TICKS, DELAY_TICKS_RESET);
      set_reg(CSR_VALID_MIN, VALID_MIN_RESET);
      set_reg(CSR_VALID_MAX, VALID_MAX_RESET);
      set_reg(CSR_FAHRENHEIT, 16'd0);
      add_item(CMD_SET_TARGET, 16'sd0, 16'sd320);
      add_item(CMD_TURN_ON, 16'sd0, 16'sd0);
      repeat (12) add_item(CMD_SAMPLE, 16'sd200, 16'sd0);
      wait_drained();

      if (mismatch_count == 0 && due_status.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### deadband_thermostat_relay_control.f
hw/rtl/dtrc_pkg.sv
hw/rtl/dtrc_conv.sv
hw/rtl/deadband_thermostat_relay_control.sv
tb/deadband_thermostat_relay_control_tb.sv
